@@ rtl/sts_pkg.sv @@
`timescale 1ns / 1ps
package sts_pkg;

  localparam logic [2:0] KIND_EOF     = 3'd0;
  localparam logic [2:0] KIND_WS      = 3'd1;
  localparam logic [2:0] KIND_SYMBOL  = 3'd2;
  localparam logic [2:0] KIND_COMMENT = 3'd3;
  localparam logic [2:0] KIND_NUMBER  = 3'd4;
  localparam logic [2:0] KIND_STRING  = 3'd5;
  localparam logic [2:0] KIND_IDENT   = 3'd6;
  localparam logic [2:0] KIND_KEYWORD = 3'd7;

  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_NUMBER   = 3'd1;
  localparam logic [2:0] ERR_CHAR     = 3'd2;
  localparam logic [2:0] ERR_ESCAPE   = 3'd3;
  localparam logic [2:0] ERR_UNCLOSED = 3'd4;

  localparam int NUM_KEYWORDS = 18;

  typedef enum logic [6:0] {
    MODE_IDLE    = 7'b0000001,
    MODE_WS      = 7'b0000010,
    MODE_SYM     = 7'b0000100,
    MODE_COMMENT = 7'b0001000,
    MODE_NUM     = 7'b0010000,
    MODE_STR     = 7'b0100000,
    MODE_WORD    = 7'b1000000
  } mode_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  err;
    logic [31:0] start;
    logic [31:0] len;
    logic        last;
  } result_t;

  localparam logic [63:0] KW_TEXT [NUM_KEYWORDS] = '{
    64'("local"), 64'("global"), 64'("fun"), 64'("return"), 64'("if"), 64'("else"),
    64'("do"), 64'("while"), 64'("for"), 64'("in"), 64'("and"), 64'("or"),
    64'("not"), 64'("break"), 64'("continue"), 64'("null"), 64'("true"), 64'("false")
  };
  localparam logic [3:0] KW_LEN [NUM_KEYWORDS] = '{
    4'd5, 4'd6, 4'd3, 4'd6, 4'd2, 4'd4, 4'd2, 4'd5, 4'd3,
    4'd2, 4'd3, 4'd2, 4'd3, 4'd5, 4'd8, 4'd4, 4'd4, 4'd5
  };

  function automatic logic is_white(logic [7:0] b);
    return (b == 8'h20) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_hex(logic [7:0] b);
    return is_digit(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
  endfunction

  function automatic logic is_base(logic [7:0] b, logic [1:0] base);
    logic r;
    case (base)
      2'd1:    r = is_hex(b);
      2'd2:    r = b >= "0" && b <= "7";
      2'd3:    r = b == "0" || b == "1";
      default: r = is_digit(b);
    endcase
    return r;
  endfunction

  function automatic logic is_one_sym(logic [7:0] b);
    logic r;
    case (b) inside
      "+", "-", "*", "/", "%", "~", "^", "&", "|", "=", ">", "<", ",", ".", ":", ";",
      "(", ")", "[", "]", "{", "}": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_long_head(logic [7:0] b);
    logic r;
    case (b) inside
      "=", "!", "<", ">", "#", "*", ".", "/": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_two(logic [7:0] p, logic [7:0] b);
    logic r;
    case ({p, b}) inside
      "==", "!=", "<=", ">=", "<<", ">>", "#(", "#[", "#{", "**", "..", "//": r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // keyword text is held first byte highest; the word register first byte lowest
  function automatic logic [63:0] to_le(logic [63:0] s, logic [3:0] n);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < n) r[8*i +: 8] = s[8*(32'(n) - 1 - i) +: 8];
    end
    return r;
  endfunction

  function automatic logic kw_hit(logic [63:0] pfx, logic [3:0] n);
    logic r;
    r = 1'b0;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      if (n == KW_LEN[k] && pfx == to_le(KW_TEXT[k], KW_LEN[k])) r = 1'b1;
    end
    return r;
  endfunction

endpackage

@@ rtl/script_token_scanner.sv @@
`timescale 1ns / 1ps
// Script tokenizer: one source byte per cycle on s_axis, byte 0 ends the text.
// Each byte is decided in the cycle it is taken; its results (at most two) go
// into a four-word result queue, and s_tready is low while fewer than two
// slots are free. Tokens that need their following byte are reported with it.
// m_tlast marks the final result of a byte. After an error, bytes are dropped
// until byte 0. Sustained rate is one byte per cycle while m_tready drains the
// queue, limited to one result word per cycle on the output.
module script_token_scanner #(
  parameter int OFFSET_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // text_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // token_kind, error_code, token_start, token_length
  output logic        m_tlast    // last_result
);

  localparam int LW = (OFFSET_WIDTH > 33) ? OFFSET_WIDTH : 33;

  sts_pkg::mode_t mode, mode_next;
  logic [2:0]  nphase, nphase_next;
  logic [1:0]  nbase, nbase_next;
  logic [1:0]  esc, esc_next;
  logic        qsingle, qsingle_next;
  logic [15:0] psym, psym_next;
  logic [63:0] prefix, prefix_next;
  logic [OFFSET_WIDTH-1:0] cur, cur_next, start, start_next;
  logic        halted, halted_next;

  sts_pkg::result_t fifo [4];
  logic [1:0] wptr, rptr;
  logic [2:0] count;

  sts_pkg::result_t r0, r1;
  logic [1:0] n;
  logic [7:0] b;
  logic       acc;
  logic [LW-1:0] dl, sl, cl;
  logic [31:0] len0, len1, st32, cur32;
  logic        sat, do_start, do_comment, done;
  logic [7:0]  p;
  logic [2:0]  ph;

  function automatic sts_pkg::result_t mk(logic [2:0] k, logic [2:0] e, logic [31:0] s,
                                          logic [31:0] l);
    sts_pkg::result_t r;
    r.kind = k;
    r.err = e;
    r.start = s;
    r.len = l;
    r.last = 1'b0;
    return r;
  endfunction

  assign b    = s_tdata;
  assign acc  = s_tvalid && s_tready;
  assign dl   = LW'(cur - start);
  assign sl   = LW'(start);
  assign cl   = LW'(cur);
  assign st32 = sl[31:0];
  assign cur32 = cl[31:0];
  assign sat  = dl >= LW'(33'h0FFFFFFFF);
  assign len0 = sat ? 32'hFFFFFFFF : dl[31:0];
  assign len1 = sat ? 32'hFFFFFFFF : dl[31:0] + 32'd1;

  always_comb begin
    mode_next = mode;
    nphase_next = nphase;
    nbase_next = nbase;
    esc_next = esc;
    qsingle_next = qsingle;
    psym_next = psym;
    prefix_next = prefix;
    start_next = start;
    halted_next = halted;
    cur_next = cur;
    r0 = mk(sts_pkg::KIND_EOF, sts_pkg::ERR_OK, 32'd0, 32'd0);
    r1 = r0;
    n = 2'd0;
    do_start = 1'b0;
    do_comment = 1'b0;
    done = 1'b0;
    p = psym[7:0];
    ph = nphase;

    if (!halted) begin
      case (mode)
        sts_pkg::MODE_WS: begin
          if (!sts_pkg::is_white(b)) begin
            r0 = mk(sts_pkg::KIND_WS, sts_pkg::ERR_OK, st32, len0);
            n = 2'd1;
            do_start = 1'b1;
          end
        end
        sts_pkg::MODE_SYM: begin
          if (psym[15:8] != 8'd0) begin
            if (b == p) begin
              mode_next = sts_pkg::MODE_IDLE;
              r0 = mk(sts_pkg::KIND_SYMBOL, sts_pkg::ERR_OK, st32, 32'd3);
            end else begin
              r0 = mk(sts_pkg::KIND_SYMBOL, sts_pkg::ERR_OK, st32, 32'd2);
              do_start = 1'b1;
            end
            n = 2'd1;
          end else if (sts_pkg::is_two(p, b)) begin
            if (p == b && (p == "<" || p == ">" || p == ".")) begin
              psym_next = {b, p};
            end else begin
              mode_next = sts_pkg::MODE_IDLE;
              r0 = mk(sts_pkg::KIND_SYMBOL, sts_pkg::ERR_OK, st32, 32'd2);
              n = 2'd1;
            end
          end else if (sts_pkg::is_one_sym(p)) begin
            r0 = mk(sts_pkg::KIND_SYMBOL, sts_pkg::ERR_OK, st32, 32'd1);
            n = 2'd1;
            do_start = 1'b1;
          end else if (p == "#") begin
            mode_next = sts_pkg::MODE_COMMENT;
            do_comment = 1'b1;
          end else begin
            r0 = mk(sts_pkg::KIND_EOF, sts_pkg::ERR_CHAR, st32, 32'd0);
            n = 2'd1;
            mode_next = sts_pkg::MODE_IDLE;
            if (b != 8'd0) halted_next = 1'b1;
          end
        end
        sts_pkg::MODE_COMMENT: begin
          do_comment = 1'b1;
        end
        sts_pkg::MODE_NUM: begin
          if (ph == 3'd0) begin
            if (b == "x" || b == "o" || b == "b") begin
              nbase_next = (b == "x") ? 2'd1 : (b == "o") ? 2'd2 : 2'd3;
              done = 1'b1;
            end
            ph = 3'd1;
            nphase_next = 3'd1;
          end
          if (!done) begin
            case (ph)
              3'd1, 3'd2: begin
                if (sts_pkg::is_base(b, nbase)) done = 1'b1;
                else if (b == "." && ph == 3'd1) begin
                  nphase_next = 3'd2;
                  done = 1'b1;
                end else if (b == "e") begin
                  nphase_next = 3'd3;
                  done = 1'b1;
                end else if (b == "i") begin
                  nphase_next = 3'd5;
                  done = 1'b1;
                end
              end
              3'd3: begin
                if (b == "+" || b == "-" || sts_pkg::is_base(b, nbase)) begin
                  nphase_next = 3'd4;
                  done = 1'b1;
                end else if (b == "i") begin
                  nphase_next = 3'd5;
                  done = 1'b1;
                end
              end
              3'd4: begin
                if (sts_pkg::is_base(b, nbase)) done = 1'b1;
                else if (b == "i") begin
                  nphase_next = 3'd5;
                  done = 1'b1;
                end
              end
              default: ;
            endcase
          end
          if (!done) begin
            n = 2'd1;
            if (sts_pkg::is_alpha(b)) begin
              r0 = mk(sts_pkg::KIND_EOF, sts_pkg::ERR_NUMBER, st32, 32'd0);
              mode_next = sts_pkg::MODE_IDLE;
              halted_next = 1'b1;
            end else begin
              r0 = mk(sts_pkg::KIND_NUMBER, sts_pkg::ERR_OK, st32, len0);
              do_start = 1'b1;
            end
          end
        end
        sts_pkg::MODE_STR: begin
          case (esc)
            2'd0: begin
              if (b == (qsingle ? 8'h27 : 8'h22)) begin
                mode_next = sts_pkg::MODE_IDLE;
                r0 = mk(sts_pkg::KIND_STRING, sts_pkg::ERR_OK, st32, len1);
                n = 2'd1;
              end else if (b == 8'd0) begin
                r0 = mk(sts_pkg::KIND_EOF, sts_pkg::ERR_UNCLOSED, st32, 32'd0);
                n = 2'd1;
                mode_next = sts_pkg::MODE_IDLE;
              end else if (b == 8'h5C) begin
                esc_next = 2'd1;
              end
            end
            2'd1: begin
              if (b == "x") esc_next = 2'd2;
              else if (b == "n" || b == "t" || b == "r" || b == "f" || b == "v" ||
                       b == "a" || b == "b" || b == "e") esc_next = 2'd0;
              else n = 2'd1;
            end
            default: begin
              if (sts_pkg::is_hex(b)) esc_next = (esc == 2'd2) ? 2'd3 : 2'd0;
              else n = 2'd1;
            end
          endcase
          if (n == 2'd1 && esc != 2'd0) begin
            r0 = mk(sts_pkg::KIND_EOF, sts_pkg::ERR_ESCAPE, st32, 32'd0);
            mode_next = sts_pkg::MODE_IDLE;
            if (b != 8'd0) halted_next = 1'b1;
          end
        end
        sts_pkg::MODE_WORD: begin
          if (sts_pkg::is_alpha(b) || sts_pkg::is_digit(b) || b == "_") begin
            if (dl < LW'(8)) prefix_next[{dl[2:0], 3'b000} +: 8] = b;
          end else begin
            r0 = mk(sts_pkg::kw_hit(prefix, (dl <= LW'(8)) ? dl[3:0] : 4'd0) ?
                    sts_pkg::KIND_KEYWORD : sts_pkg::KIND_IDENT,
                    sts_pkg::ERR_OK, st32, len0);
            n = 2'd1;
            do_start = 1'b1;
          end
        end
        default: do_start = 1'b1;
      endcase

      if (do_comment) begin
        if (b == 8'h0A) begin
          mode_next = sts_pkg::MODE_IDLE;
          r0 = mk(sts_pkg::KIND_COMMENT, sts_pkg::ERR_OK, st32, len1);
          n = 2'd1;
        end else if (b == 8'd0) begin
          r0 = mk(sts_pkg::KIND_COMMENT, sts_pkg::ERR_OK, st32, len0);
          n = 2'd1;
          do_start = 1'b1;
        end
      end

      if (do_start) begin
        start_next = cur;
        mode_next = sts_pkg::MODE_IDLE;
        r1 = mk(sts_pkg::KIND_EOF, sts_pkg::ERR_OK, 32'd0, 32'd0);
        if (b == 8'd0) begin
          r1 = mk(sts_pkg::KIND_EOF, sts_pkg::ERR_OK, cur32, 32'd0);
        end else if (sts_pkg::is_white(b)) begin
          mode_next = sts_pkg::MODE_WS;
        end else if (sts_pkg::is_long_head(b)) begin
          psym_next = {8'd0, b};
          mode_next = sts_pkg::MODE_SYM;
        end else if (sts_pkg::is_one_sym(b)) begin
          r1 = mk(sts_pkg::KIND_SYMBOL, sts_pkg::ERR_OK, cur32, 32'd1);
        end else if (sts_pkg::is_digit(b)) begin
          mode_next = sts_pkg::MODE_NUM;
          nphase_next = 3'd0;
          nbase_next = 2'd0;
        end else if (b == 8'h22 || b == 8'h27) begin
          mode_next = sts_pkg::MODE_STR;
          qsingle_next = (b == 8'h27);
          esc_next = 2'd0;
        end else if (sts_pkg::is_alpha(b) || b == "_") begin
          mode_next = sts_pkg::MODE_WORD;
          prefix_next = {56'd0, b};
        end else begin
          r1 = mk(sts_pkg::KIND_EOF, sts_pkg::ERR_CHAR, cur32, 32'd0);
          halted_next = 1'b1;
        end
        if (b == 8'd0 || (!sts_pkg::is_white(b) && !sts_pkg::is_long_head(b) &&
            (sts_pkg::is_one_sym(b) || (!sts_pkg::is_digit(b) && b != 8'h22 &&
             b != 8'h27 && !sts_pkg::is_alpha(b) && b != "_")))) begin
          if (n == 2'd0) r0 = r1;
          n = n + 2'd1;
        end
      end
    end

    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;

    if (b == 8'd0) begin
      mode_next = sts_pkg::MODE_IDLE;
      nphase_next = 3'd0;
      nbase_next = 2'd0;
      esc_next = 2'd0;
      qsingle_next = 1'b0;
      psym_next = '0;
      prefix_next = '0;
      cur_next = '0;
      start_next = '0;
      halted_next = 1'b0;
    end else if (cur != '1) begin
      cur_next = cur + 1'b1;
    end
  end

  assign s_tready = count <= 3'd2;
  assign m_tvalid = count != 3'd0;
  assign m_tdata  = {2'b00, fifo[rptr].len, fifo[rptr].start, fifo[rptr].err,
                     fifo[rptr].kind};
  assign m_tlast  = fifo[rptr].last;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= sts_pkg::MODE_IDLE;
      nphase <= '0;
      nbase <= '0;
      esc <= '0;
      qsingle <= 1'b0;
      psym <= '0;
      prefix <= '0;
      cur <= '0;
      start <= '0;
      halted <= 1'b0;
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (acc) begin
        mode <= mode_next;
        nphase <= nphase_next;
        nbase <= nbase_next;
        esc <= esc_next;
        qsingle <= qsingle_next;
        psym <= psym_next;
        prefix <= prefix_next;
        cur <= cur_next;
        start <= start_next;
        halted <= halted_next;
        wptr <= wptr + n;
      end
      if (m_tvalid && m_tready) rptr <= rptr + 2'd1;
      count <= count + (acc ? {1'b0, n} : 3'd0) - ((m_tvalid && m_tready) ? 3'd1 : 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (acc && n != 2'd0) fifo[wptr] <= r0;
    if (acc && n == 2'd2) fifo[wptr + 2'd1] <= r1;
  end

endmodule

@@ rtl/sts_checker.sv @@
`timescale 1ns / 1ps
module sts_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic        m_tlast
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled word changed");

  a_err_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5:3] != sts_pkg::ERR_OK |->
      m_tdata[2:0] == sts_pkg::KIND_EOF && m_tdata[69:38] == 32'd0)
    else $error("error word with kind or length set");

  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] == sts_pkg::KIND_EOF |-> m_tlast && m_tdata[69:38] == 32'd0)
    else $error("end or error word not last");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[71:70] == 2'b00 && (m_tdata[5:3] == sts_pkg::ERR_OK ||
      m_tdata[5:3] == sts_pkg::ERR_NUMBER || m_tdata[5:3] == sts_pkg::ERR_CHAR ||
      m_tdata[5:3] == sts_pkg::ERR_ESCAPE || m_tdata[5:3] == sts_pkg::ERR_UNCLOSED))
    else $error("bad error code or padding");

endmodule

bind script_token_scanner sts_checker u_sts_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
